// ----- rtl/crr_pkg.sv -----
// Package for the chained range remap unit: transaction types, opcodes,
// state encoding and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crr_pkg;

    localparam int CRR_NUM_STAGES        = 7;
    localparam int CRR_ENTRIES_PER_STAGE = 64;
    localparam int STAGE_W               = 3;
    localparam int SLOT_W                = 6;
    localparam int DATA_W                = 32;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_LOAD      = 1'b1;

    typedef struct packed {
        logic                opcode;
        logic [STAGE_W-1:0]  stage_select;
        logic [SLOT_W-1:0]   slot_select;
        logic [DATA_W-1:0]   dest_start;
        logic [DATA_W-1:0]   source_start;
        logic [DATA_W-1:0]   span_length;
        logic [DATA_W-1:0]   value_in;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]   stage_value;
        logic [STAGE_W-1:0]  stage_number;
        logic                hit;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [DATA_W-1:0]   dest;
        logic [DATA_W-1:0]   source;
        logic [DATA_W-1:0]   length;
    } t_entry;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/crr_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module crr_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 448
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/chained_range_remap_unit.sv -----
// Top level of the chained range remap unit: command decode, entry scan and
// result output. Depends on crr_pkg and crr_ram.
`timescale 1ns / 1ps
`default_nettype none

// After reset the unit clears its entry table, one entry per cycle, with busy
// high. A load transaction writes its entry, if stage and slot are in range,
// while the unit stays idle. A translate transaction scans the entries of each
// stage in order through the single read port of the entry RAM, one entry per
// cycle but for the read dropped at a hit, and moves to the next stage at the
// first hit; it keeps busy high until the result of the last stage. Each stage
// yields one result, shown for a single cycle with o_strobe high; the receiver
// cannot stall, so results must be taken as they come.
module chained_range_remap_unit
    import crr_pkg::*;
#(
    parameter int NUM_STAGES        = CRR_NUM_STAGES,
    parameter int ENTRIES_PER_STAGE = CRR_ENTRIES_PER_STAGE
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    input  wire t_cmd    i_cmd,
    output logic         busy,
    output logic         o_strobe,
    output t_result      o_result
);

    localparam int DEPTH = NUM_STAGES * ENTRIES_PER_STAGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;
    localparam int ENT_W = $bits(t_entry);

    localparam logic [AW-1:0]      LAST_ADDR  = AW'(DEPTH - 1);
    localparam logic [AW-1:0]      STAGE_STEP = AW'(ENTRIES_PER_STAGE);
    localparam logic [EW-1:0]      LAST_ENTRY = EW'(ENTRIES_PER_STAGE - 1);
    localparam logic [STAGE_W-1:0] LAST_STAGE = STAGE_W'(NUM_STAGES - 1);

    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_value, n_value;
    logic                r_iss_active, n_iss_active;
    logic [AW-1:0]       r_iss_addr, n_iss_addr;
    logic [AW-1:0]       r_iss_base, n_iss_base;
    logic [STAGE_W-1:0]  r_iss_stage, n_iss_stage;
    logic [EW-1:0]       r_iss_entry, n_iss_entry;
    logic                r_rd_valid, n_rd_valid;
    logic                r_rd_last, n_rd_last;
    logic [AW-1:0]       r_rd_base, n_rd_base;
    logic [STAGE_W-1:0]  r_rd_stage, n_rd_stage;
    logic                r_strobe, n_strobe;
    t_result             r_result, n_result;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    t_entry              ram_wdata;
    logic                ram_re;
    t_entry              ram_rdata;

    logic [DATA_W-1:0]   load_lin;
    logic                load_in_range;
    logic [DATA_W-1:0]   offset;
    logic [DATA_W-1:0]   mapped;
    logic                match;

    crr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_iss_addr),
        .o_rdata (ram_rdata)
    );

    assign load_lin      = DATA_W'(i_cmd.stage_select) * DATA_W'(ENTRIES_PER_STAGE)
                         + DATA_W'(i_cmd.slot_select);
    assign load_in_range = (DATA_W'(i_cmd.stage_select) < DATA_W'(NUM_STAGES))
                        && (DATA_W'(i_cmd.slot_select) < DATA_W'(ENTRIES_PER_STAGE));

    assign offset = r_value - ram_rdata.source;
    assign mapped = ram_rdata.dest + offset;
    assign match  = (ram_rdata.length != '0) && (r_value >= ram_rdata.source)
                 && (offset < ram_rdata.length);

    always_comb begin
        n_state      = r_state;
        n_value      = r_value;
        n_iss_active = r_iss_active;
        n_iss_addr   = r_iss_addr;
        n_iss_base   = r_iss_base;
        n_iss_stage  = r_iss_stage;
        n_iss_entry  = r_iss_entry;
        n_rd_valid   = 1'b0;
        n_rd_last    = r_rd_last;
        n_rd_base    = r_rd_base;
        n_rd_stage   = r_rd_stage;
        n_strobe     = 1'b0;
        n_result     = r_result;
        ram_we       = 1'b0;
        ram_waddr    = r_iss_addr;
        ram_wdata    = '0;
        ram_re       = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_iss_addr == LAST_ADDR) begin
                    n_state    = ST_IDLE;
                    n_iss_addr = '0;
                end else begin
                    n_iss_addr = r_iss_addr + AW'(1);
                end
            end
            ST_IDLE: begin
                if (start) begin
                    if (i_cmd.opcode == OP_LOAD) begin
                        ram_we    = load_in_range;
                        ram_waddr = load_lin[AW-1:0];
                        ram_wdata = '{dest:   i_cmd.dest_start,
                                      source: i_cmd.source_start,
                                      length: i_cmd.span_length};
                    end else begin
                        n_state      = ST_RUN;
                        n_value      = i_cmd.value_in;
                        n_iss_active = 1'b1;
                        n_iss_addr   = '0;
                        n_iss_base   = '0;
                        n_iss_stage  = '0;
                        n_iss_entry  = '0;
                    end
                end
            end
            ST_RUN: begin
                if (r_iss_active) begin
                    ram_re     = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_stage = r_iss_stage;
                    n_rd_base  = r_iss_base;
                    n_rd_last  = (r_iss_entry == LAST_ENTRY);
                    n_iss_addr = r_iss_addr + AW'(1);
                    if (r_iss_entry == LAST_ENTRY) begin
                        n_iss_entry = '0;
                        if (r_iss_stage == LAST_STAGE) begin
                            n_iss_active = 1'b0;
                        end else begin
                            n_iss_stage = r_iss_stage + STAGE_W'(1);
                            n_iss_base  = r_iss_base + STAGE_STEP;
                        end
                    end else begin
                        n_iss_entry = r_iss_entry + EW'(1);
                    end
                end

                if (r_rd_valid && (match || r_rd_last)) begin
                    n_strobe              = 1'b1;
                    n_result.stage_value  = match ? mapped : r_value;
                    n_result.stage_number = r_rd_stage;
                    n_result.hit          = match;
                    n_result.last         = (r_rd_stage == LAST_STAGE);
                    n_value               = match ? mapped : r_value;
                    if (r_rd_stage == LAST_STAGE) begin
                        n_state      = ST_IDLE;
                        n_iss_active = 1'b0;
                        n_rd_valid   = 1'b0;
                    end else if (!r_rd_last) begin
                        // The read in flight belongs to the stage just left.
                        n_rd_valid   = 1'b0;
                        n_iss_active = 1'b1;
                        n_iss_stage  = r_rd_stage + STAGE_W'(1);
                        n_iss_entry  = '0;
                        n_iss_base   = r_rd_base + STAGE_STEP;
                        n_iss_addr   = r_rd_base + STAGE_STEP;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_iss_active <= 1'b0;
            r_iss_addr   <= '0;
            r_rd_valid   <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_iss_active <= n_iss_active;
            r_iss_addr   <= n_iss_addr;
            r_rd_valid   <= n_rd_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value     <= n_value;
        r_iss_base  <= n_iss_base;
        r_iss_stage <= n_iss_stage;
        r_iss_entry <= n_iss_entry;
        r_rd_last   <= n_rd_last;
        r_rd_base   <= n_rd_base;
        r_rd_stage  <= n_rd_stage;
        r_result    <= n_result;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ----- verif/tb_chained_range_remap_unit.sv -----
// Self-checking testbench for chained_range_remap_unit: directed and random load and
// translate transactions, with every stage result checked against a local model of the
// stage tables. Depends on crr_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_chained_range_remap_unit;
    import crr_pkg::*;

    localparam int NSTAGE       = CRR_NUM_STAGES;
    localparam int NSLOT        = CRR_ENTRIES_PER_STAGE;
    localparam int TABLE_SIZE   = NSTAGE * NSLOT;
    localparam int DRAIN_CYCLES = TABLE_SIZE + 16;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    logic [DATA_W-1:0] model_dest   [0:TABLE_SIZE-1];
    logic [DATA_W-1:0] model_source [0:TABLE_SIZE-1];
    logic [DATA_W-1:0] model_length [0:TABLE_SIZE-1];

    t_result awaited_results[$];
    int      mismatch_count;

    chained_range_remap_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [DATA_W-1:0] remap_in_stage(input int stg,
                                                         input logic [DATA_W-1:0] v,
                                                         output logic matched);
        int                idx;
        logic [DATA_W-1:0] offs;
        matched = 1'b0;
        for (int e = 0; e < NSLOT; e++) begin
            idx  = stg * NSLOT + e;
            offs = v - model_source[idx];
            if (model_length[idx] != 0 && v >= model_source[idx] && offs < model_length[idx]) begin
                matched = 1'b1;
                return model_dest[idx] + offs;
            end
        end
        return v;
    endfunction

    task automatic predict_remap(input t_cmd cmd);
        int                idx;
        logic [DATA_W-1:0] v;
        logic              matched;
        t_result           r;
        if (cmd.opcode == OP_LOAD) begin
            if (cmd.stage_select < NSTAGE && cmd.slot_select < NSLOT) begin
                idx = cmd.stage_select * NSLOT + cmd.slot_select;
                model_dest[idx]   = cmd.dest_start;
                model_source[idx] = cmd.source_start;
                model_length[idx] = cmd.span_length;
            end
        end else begin
            v = cmd.value_in;
            for (int s = 0; s < NSTAGE; s++) begin
                v              = remap_in_stage(s, v, matched);
                r.stage_value  = v;
                r.stage_number = STAGE_W'(s);
                r.hit          = matched;
                r.last         = (s == NSTAGE - 1);
                awaited_results.insert(awaited_results.size(), r);
            end
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_result exp_r;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (awaited_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result: value %h stage %0d hit %b last %b",
                             o_result.stage_value, o_result.stage_number,
                             o_result.hit, o_result.last);
                end
            end else begin
                exp_r = awaited_results.pop_front();
                if (o_result.stage_value !== exp_r.stage_value ||
                    o_result.stage_number !== exp_r.stage_number ||
                    o_result.hit !== exp_r.hit || o_result.last !== exp_r.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("Result mismatch: expected value %h stage %0d hit %b last %b, ",
                               exp_r.stage_value, exp_r.stage_number, exp_r.hit,
                               exp_r.last);
                        $display("got value %h stage %0d hit %b last %b",
                                 o_result.stage_value, o_result.stage_number,
                                 o_result.hit, o_result.last);
                    end
                end
            end
        end
    end

    function automatic t_cmd noise_cmd();
        t_cmd c;
        c.opcode       = 1'($urandom_range(0, 1));
        c.stage_select = STAGE_W'($urandom_range(0, 7));
        c.slot_select  = SLOT_W'($urandom_range(0, 63));
        c.dest_start   = $urandom;
        c.source_start = $urandom;
        c.span_length  = $urandom;
        c.value_in     = $urandom;
        return c;
    endfunction

    task automatic issue_cmd(input t_cmd cmd);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_remap(cmd);
    endtask

    task automatic sender_gap(input int idle_pct);
        while ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic translate(input logic [DATA_W-1:0] v);
        t_cmd c;
        c          = noise_cmd();
        c.opcode   = OP_TRANSLATE;
        c.value_in = v;
        issue_cmd(c);
    endtask

    task automatic load_entry(input int stg, input int slot, input logic [DATA_W-1:0] d,
                              input logic [DATA_W-1:0] s, input logic [DATA_W-1:0] l);
        t_cmd c;
        c              = noise_cmd();
        c.opcode       = OP_LOAD;
        c.stage_select = STAGE_W'(stg);
        c.slot_select  = SLOT_W'(slot);
        c.dest_start   = d;
        c.source_start = s;
        c.span_length  = l;
        issue_cmd(c);
    endtask

    task automatic test_empty_tables();
        translate(32'h0000_0000);
        translate(32'hFFFF_FFFF);
        translate($urandom);
    endtask

    task automatic test_ignored_load();
        load_entry(7, 63, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        translate(32'h0000_1234);
    endtask

    task automatic test_extreme_entries();
        load_entry(0, 0, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001);
        load_entry(1, 63, 32'h0000_0010, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
        load_entry(2, 0, 32'hFFFF_FFF8, 32'h0000_0010, 32'h0000_0020);
        translate(32'h0000_0000);
        translate(32'hFFFF_FFFF);
        translate(32'hFFFF_FFF0);
        translate(32'hFFFF_FFEF);
    endtask

    task automatic test_slot_priority();
        load_entry(3, 9, 32'h0000_1000, 32'h0000_0000, 32'h0000_0100);
        load_entry(3, 4, 32'h0000_2000, 32'h0000_0005, 32'h0000_0010);
        load_entry(3, 2, 32'h0000_3000, 32'h0000_0000, 32'h0000_0000);
        load_entry(6, 63, 32'hAAAA_AAAA, 32'h0000_2002, 32'h0000_0001);
        translate(32'h0000_0007);
        translate(32'h0000_0004);
        translate(32'h0000_0014);
        translate(32'h0000_0015);
    endtask

    task automatic test_random_traffic(input int n_items, input int idle_pct);
        t_cmd c;
        int   counted;
        counted = 0;
        while (counted < n_items) begin
            c = noise_cmd();
            if ($urandom_range(0, 99) < 35) begin
                c.opcode = OP_LOAD;
                if ($urandom_range(0, 99) < 60) c.slot_select = SLOT_W'($urandom_range(0, 11));
                if ($urandom_range(0, 99) < 70) c.source_start = $urandom_range(0, 4095);
                if ($urandom_range(0, 99) < 70) c.dest_start = $urandom_range(0, 4095);
                case ($urandom_range(0, 9))
                    0: c.span_length = '0;
                    1, 2, 3: c.span_length = $urandom;
                    default: c.span_length = $urandom_range(1, 1024);
                endcase
            end else begin
                c.opcode = OP_TRANSLATE;
                if ($urandom_range(0, 99) < 70) c.value_in = $urandom_range(0, 4095);
            end
            issue_cmd(c);
            if (!(c.opcode == OP_LOAD && c.stage_select >= NSTAGE)) counted++;
            sender_gap(idle_pct);
        end
    endtask

    initial begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
            model_dest[i]   = '0;
            model_source[i] = '0;
            model_length[i] = '0;
        end
        mismatch_count = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cmd          = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tables();
        test_ignored_load();
        test_extreme_entries();
        test_slot_priority();
        wait_for_results();

        test_random_traffic(75, 0);
        wait_for_results();
        test_random_traffic(75, 78);
        wait_for_results();
        test_random_traffic(70, 16);
        wait_for_results();

        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
